@@ src/jtc_pkg.sv @@
// ---------------------------------------------------------------------------
// jtc_pkg: shared types for the JSON token classifier
// Span word layout, token class codes and queue sizing used by the scanner,
// the span queue and the top level.
// ---------------------------------------------------------------------------
package jtc_pkg;

	// Most spans one text byte can produce
	localparam int MaxSpans   = 3;
	// Span queue sizing
	localparam int QueueDepth = 8;
	localparam int QueueAw    = 3;

	typedef enum logic [3:0] {
		CLS_PLAIN    = 4'd0,
		CLS_KEY      = 4'd1,
		CLS_STRING   = 4'd2,
		CLS_NUMBER   = 4'd3,
		CLS_LITERAL  = 4'd4,
		CLS_OPERATOR = 4'd5,
		CLS_CALL     = 4'd6,
		CLS_PUNCT    = 4'd7,
		CLS_IDENT    = 4'd8
	} span_class_t;

	typedef struct packed {
		logic [15:0] start;
		logic [15:0] length;
		span_class_t cls;
		logic        last;
		logic        ovf;
	} span_t;

	// Spans produced by one text byte, in text order
	typedef struct packed {
		logic [1:0]  count;
		span_t [2:0] span;
	} span_batch_t;

endpackage

@@ src/jtc_scanner.sv @@
// ---------------------------------------------------------------------------
// jtc_scanner: per-byte token scanner
// Holds the scan state and, for each accepted byte, works out in one pass the
// up to three spans that the byte closes, in text order.
// ---------------------------------------------------------------------------
module jtc_scanner #(
	parameter int PB = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [7:0]           text_byte,
	input  logic                 end_of_text,
	output jtc_pkg::span_batch_t batch
);
	import jtc_pkg::*;

	localparam logic [PB-1:0] PosMax = '1;
	localparam int            ExtW   = (PB > 16) ? PB : 16;
	localparam int            NWords = 6;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_STR,
		MODE_STR_ESC,
		MODE_STR_DONE,
		MODE_WORD,
		MODE_WORD_DONE,
		MODE_MINUS,
		MODE_NUM
	} mode_t;

	mode_t         mode_q, mode_n;
	logic [PB-1:0] pos_q, pos_n;
	logic [PB-1:0] ps_q, ps_n;
	logic [PB-1:0] pl_q, pl_n;
	logic [PB-1:0] br_q, br_n;
	logic [5:0]    flags_q, flags_n;
	logic          dollar_q, dollar_n;
	logic          ovf_q, ovf_n;
	logic          exp_q, exp_n;

	logic [4:0]    cv;
	span_t         cs [5];
	logic          redo;
	logic [2:0]    cnt;
	logic [7:0]    c;

	// Literal word table
	function automatic logic [3:0] word_len(input logic [2:0] w);
		case (w)
			3'd0:    return 4'd4;
			3'd1:    return 4'd5;
			3'd2:    return 4'd4;
			3'd3:    return 4'd9;
			3'd4:    return 4'd3;
			3'd5:    return 4'd8;
			default: return 4'd0;
		endcase
	endfunction

	function automatic logic [7:0] word_char(input logic [2:0] w, input logic [3:0] i);
		logic [71:0] s;
		logic [3:0]  n;
		logic [6:0]  off;
		n = word_len(w);
		case (w)
			3'd0:    s = 72'("true");
			3'd1:    s = 72'("false");
			3'd2:    s = 72'("null");
			3'd3:    s = 72'("undefined");
			3'd4:    s = 72'("NaN");
			3'd5:    s = 72'("Infinity");
			default: s = '0;
		endcase
		if (i < n) begin
			off = 7'(8 * (int'(n) - 1 - int'(i)));
			return s[off +: 8];
		end
		return 8'h00;
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return (b == 8'h20) || (b == 8'h09);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= "0") && (b <= "9");
	endfunction

	function automatic logic id_start(input logic [7:0] b);
		return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"))
			|| (b == "_") || (b == "$");
	endfunction

	function automatic logic is_punct(input logic [7:0] b);
		return (b == "{") || (b == "}") || (b == "[") || (b == "]")
			|| (b == ",") || (b == ":");
	endfunction

	function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
		return (v == PosMax) ? v : v + 1'b1;
	endfunction

	// Drop every literal word that disagrees with byte b at offset idx
	function automatic logic [5:0] match_update(input logic [5:0] f,
			input logic [PB-1:0] idx, input logic [7:0] b);
		logic [5:0] r;
		r = f;
		for (int w = 0; w < NWords; w++) begin
			if (!((idx < PB'(word_len(3'(w)))) && (word_char(3'(w), idx[3:0]) == b)))
				r[w] = 1'b0;
		end
		return r;
	endfunction

	function automatic span_class_t word_class(input logic [5:0] f,
			input logic [PB-1:0] len, input logic dol);
		logic hit;
		hit = 1'b0;
		for (int w = 0; w < NWords; w++) begin
			if (f[w] && (len == PB'(word_len(3'(w)))))
				hit = 1'b1;
		end
		if (hit)
			return CLS_LITERAL;
		return dol ? CLS_OPERATOR : CLS_IDENT;
	endfunction

	// Offset just past a pending token, saturated
	function automatic logic [PB-1:0] blank_start(input logic [PB-1:0] s,
			input logic [PB-1:0] l);
		logic [PB:0] sum;
		sum = {1'b0, s} + {1'b0, l};
		return sum[PB] ? PosMax : sum[PB-1:0];
	endfunction

	function automatic span_t mk(input logic [PB-1:0] s, input logic [PB-1:0] l,
			input span_class_t k);
		span_t          r;
		logic [ExtW-1:0] s_ext;
		logic [ExtW-1:0] l_ext;
		s_ext    = ExtW'(s);
		l_ext    = ExtW'(l);
		r.start  = s_ext[15:0];
		r.length = l_ext[15:0];
		r.cls    = k;
		r.last   = 1'b0;
		r.ovf    = 1'b0;
		return r;
	endfunction

	assign c = text_byte;

	// Next state and spans for the byte on the input
	always_comb begin
		mode_n   = mode_q;
		ps_n     = ps_q;
		pl_n     = pl_q;
		br_n     = br_q;
		flags_n  = flags_q;
		dollar_n = dollar_q;
		exp_n    = exp_q;
		ovf_n    = ovf_q | (pos_q == PosMax);
		pos_n    = sat_inc(pos_q);
		redo     = 1'b0;
		cv       = '0;
		for (int i = 0; i < 5; i++)
			cs[i] = '0;

		// Continue or close the pending token
		case (mode_q)
			MODE_STR: begin
				pl_n = sat_inc(pl_q);
				if (c == "\\") begin
					mode_n = MODE_STR_ESC;
				end else if (c == "\"") begin
					mode_n = MODE_STR_DONE;
					br_n   = '0;
				end
			end
			MODE_STR_ESC: begin
				pl_n   = sat_inc(pl_q);
				mode_n = MODE_STR;
			end
			MODE_STR_DONE: begin
				if (is_blank(c)) begin
					br_n = sat_inc(br_q);
				end else begin
					cv[0] = 1'b1;
					cs[0] = mk(ps_q, pl_q, (c == ":") ? CLS_KEY : CLS_STRING);
					cv[1] = (br_q != '0);
					cs[1] = mk(blank_start(ps_q, pl_q), br_q, CLS_PLAIN);
					redo  = 1'b1;
				end
			end
			MODE_WORD: begin
				if (id_start(c) || is_digit(c)) begin
					flags_n = match_update(flags_q, pl_q, c);
					pl_n    = sat_inc(pl_q);
				end else if (is_blank(c)) begin
					mode_n = MODE_WORD_DONE;
					br_n   = PB'(1);
				end else begin
					cv[0] = 1'b1;
					cs[0] = mk(ps_q, pl_q,
						(c == "(") ? CLS_CALL : word_class(flags_q, pl_q, dollar_q));
					redo  = 1'b1;
				end
			end
			MODE_WORD_DONE: begin
				if (is_blank(c)) begin
					br_n = sat_inc(br_q);
				end else begin
					cv[0] = 1'b1;
					cs[0] = mk(ps_q, pl_q,
						(c == "(") ? CLS_CALL : word_class(flags_q, pl_q, dollar_q));
					cv[1] = (br_q != '0);
					cs[1] = mk(blank_start(ps_q, pl_q), br_q, CLS_PLAIN);
					redo  = 1'b1;
				end
			end
			MODE_MINUS: begin
				if (is_digit(c)) begin
					mode_n = MODE_NUM;
					pl_n   = sat_inc(pl_q);
					exp_n  = 1'b0;
				end else begin
					cv[0] = 1'b1;
					cs[0] = mk(ps_q, PB'(1), CLS_PLAIN);
					redo  = 1'b1;
				end
			end
			MODE_NUM: begin
				if (is_digit(c) || (c == ".") || (c == "e") || (c == "E")
						|| (((c == "+") || (c == "-")) && exp_q)) begin
					pl_n  = sat_inc(pl_q);
					exp_n = (c == "e") || (c == "E");
				end else begin
					cv[0] = 1'b1;
					cs[0] = mk(ps_q, pl_q, CLS_NUMBER);
					redo  = 1'b1;
				end
			end
			default: begin
				redo = 1'b1;
			end
		endcase

		// Start a new token from this byte
		if (redo) begin
			mode_n = MODE_IDLE;
			br_n   = '0;
			if (is_blank(c)) begin
				cv[2] = 1'b1;
				cs[2] = mk(pos_q, PB'(1), CLS_PLAIN);
			end else begin
				ps_n = pos_q;
				pl_n = PB'(1);
				if (c == "\"") begin
					mode_n = MODE_STR;
				end else if (id_start(c)) begin
					mode_n   = MODE_WORD;
					flags_n  = match_update(6'h3f, '0, c);
					dollar_n = (c == "$");
				end else if (is_digit(c)) begin
					mode_n = MODE_NUM;
					exp_n  = 1'b0;
				end else if (c == "-") begin
					mode_n = MODE_MINUS;
				end else begin
					cv[2] = 1'b1;
					cs[2] = mk(pos_q, PB'(1), is_punct(c) ? CLS_PUNCT : CLS_PLAIN);
				end
			end
		end

		// Flush whatever is pending at end of text
		if (end_of_text) begin
			case (mode_n)
				MODE_STR, MODE_STR_ESC, MODE_STR_DONE: begin
					cv[3] = 1'b1;
					cs[3] = mk(ps_n, pl_n, CLS_STRING);
					cv[4] = (br_n != '0);
					cs[4] = mk(blank_start(ps_n, pl_n), br_n, CLS_PLAIN);
				end
				MODE_WORD, MODE_WORD_DONE: begin
					cv[3] = 1'b1;
					cs[3] = mk(ps_n, pl_n, word_class(flags_n, pl_n, dollar_n));
					cv[4] = (br_n != '0);
					cs[4] = mk(blank_start(ps_n, pl_n), br_n, CLS_PLAIN);
				end
				MODE_MINUS: begin
					cv[3] = 1'b1;
					cs[3] = mk(ps_n, PB'(1), CLS_PLAIN);
				end
				MODE_NUM: begin
					cv[3] = 1'b1;
					cs[3] = mk(ps_n, pl_n, CLS_NUMBER);
				end
				default: begin
				end
			endcase
		end

		// Pack the spans in text order
		batch = '0;
		cnt   = '0;
		for (int i = 0; i < 5; i++) begin
			if (cv[i] && (cnt < 3'(MaxSpans))) begin
				batch.span[cnt[1:0]] = cs[i];
				cnt = cnt + 3'd1;
			end
		end
		batch.count = cnt[1:0];
		for (int i = 0; i < MaxSpans; i++)
			batch.span[i].ovf = ovf_n;
		if (end_of_text && (cnt != '0))
			batch.span[cnt[1:0] - 2'd1].last = 1'b1;

		// Return to the reset state for the next text
		if (end_of_text) begin
			mode_n   = MODE_IDLE;
			pos_n    = '0;
			ps_n     = '0;
			pl_n     = '0;
			br_n     = '0;
			flags_n  = 6'h3f;
			dollar_n = 1'b0;
			ovf_n    = 1'b0;
			exp_n    = 1'b0;
		end
	end

	// Hold scan state, advance on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			pos_q    <= '0;
			ps_q     <= '0;
			pl_q     <= '0;
			br_q     <= '0;
			flags_q  <= 6'h3f;
			dollar_q <= 1'b0;
			ovf_q    <= 1'b0;
			exp_q    <= 1'b0;
		end else if (fire) begin
			mode_q   <= mode_n;
			pos_q    <= pos_n;
			ps_q     <= ps_n;
			pl_q     <= pl_n;
			br_q     <= br_n;
			flags_q  <= flags_n;
			dollar_q <= dollar_n;
			ovf_q    <= ovf_n;
			exp_q    <= exp_n;
		end
	end

	// End of text leaves the scanner back at its reset point
	a_eot_resets: assert property (@(posedge clk) disable iff (!arst_n)
		fire && end_of_text |=> (pos_q == '0) && (mode_q == MODE_IDLE) && !ovf_q)
		else $error("scanner not reset after end of text");

	// Overflow is only seen with a saturated position
	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (pos_q == PosMax))
		else $error("overflow flag without saturated position");

	// Position advances by one per byte below saturation
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !end_of_text && (pos_q != PosMax) |=> pos_q == $past(pos_q) + 1'b1)
		else $error("byte position did not advance");

endmodule

@@ src/jtc_span_queue.sv @@
// ---------------------------------------------------------------------------
// jtc_span_queue: span output queue
// Takes up to three spans per cycle from the scanner and hands them out one
// word per cycle on the output channel while out_ready is high.
// ---------------------------------------------------------------------------
module jtc_span_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  jtc_pkg::span_batch_t batch,
	output logic                 room,
	output logic                 out_valid,
	input  logic                 out_ready,
	output jtc_pkg::span_t       head
);
	import jtc_pkg::*;

	span_t              mem_q [QueueDepth];
	logic [QueueAw-1:0] head_q;
	logic [QueueAw-1:0] tail_q;
	logic [QueueAw:0]   count_q;
	logic               pop;
	logic [1:0]         n_push;

	assign room      = count_q <= (QueueAw + 1)'(QueueDepth - MaxSpans);
	assign out_valid = count_q != '0;
	assign head      = mem_q[head_q];
	assign pop       = out_valid && out_ready;
	assign n_push    = push ? batch.count : 2'd0;

	// Write the batch behind the tail
	always_ff @(posedge clk) begin
		for (int i = 0; i < MaxSpans; i++) begin
			if (push && (2'(i) < batch.count))
				mem_q[tail_q + QueueAw'(i)] <= batch.span[i];
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + QueueAw'(n_push);
			if (pop)
				head_q <= head_q + 1'b1;
			count_q <= count_q + (QueueAw + 1)'(n_push) - (QueueAw + 1)'(pop);
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QueueAw + 1)'(QueueDepth))
		else $error("span queue overfilled");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> room)
		else $error("span queue written without room");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - 1'b1)
		else $error("span queue occupancy wrong after read");

endmodule

@@ src/json_token_classifier.sv @@
// ---------------------------------------------------------------------------
// json_token_classifier: streaming token classifier for JSON-like text
// Scans one text byte per word and returns token spans (start, length, class)
// in text order.
//
//   Channel | Handshake           | Payload
//   --------+---------------------+------------------------------------------
//   input   | in_valid/in_ready   | text_byte, end_of_text
//   output  | out_valid/out_ready | span_start, span_length, span_class,
//           |                     | final_span, position_overflow
//
// One text byte is taken per cycle; its spans enter the queue at the same edge
// and the first can leave on the next cycle, one span per cycle while
// out_ready is high. Input is held off while the eight-entry span queue has
// fewer than three free entries, so a byte that closes several spans slows
// the input only when the output side stalls or falls behind.
// Reset returns the scanner to its idle state and empties the queue.
// ---------------------------------------------------------------------------
module json_token_classifier #(
	parameter int POSITION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] span_start,
	output logic [15:0] span_length,
	output logic [3:0]  span_class,
	output logic        final_span,
	output logic        position_overflow
);
	import jtc_pkg::*;

	logic        in_fire;
	logic        room;
	span_batch_t batch;
	span_t       head;

	assign in_ready = room;
	assign in_fire  = in_valid && room;

	// Scan the incoming word
	jtc_scanner #(
		.PB (POSITION_BITS)
	) u_scanner (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (in_fire),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.batch       (batch)
	);

	// Queue spans for the output channel
	jtc_span_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_fire),
		.batch     (batch),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign span_start        = head.start;
	assign span_length       = head.length;
	assign span_class        = head.cls;
	assign final_span        = head.last;
	assign position_overflow = head.ovf;

endmodule

@@ tb/sv/jtc_span_check_pkg.sv @@
// ---------------------------------------------------------------------------
// jtc_span_check_pkg: span prediction and checking for the token classifier
// Tracks the scanner state for every accepted text word, predicts the spans
// that word releases and checks each span leaving the block against the
// oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

package jtc_span_check_pkg;

	import jtc_pkg::*;

	localparam int unsigned PositionBits = 16;
	localparam int unsigned PosMax       = (1 << PositionBits) - 1;

	typedef enum int {
		SCAN_IDLE,
		SCAN_STR,
		SCAN_STR_ESC,
		SCAN_STR_DONE,
		SCAN_WORD,
		SCAN_WORD_DONE,
		SCAN_MINUS,
		SCAN_NUM
	} scan_mode_t;

	class span_tracker;
		span_t       spans_due[$];
		int unsigned mismatches;
		string       words[6];

		scan_mode_t  mode;
		int unsigned position;
		int unsigned tok_start;
		int unsigned tok_len;
		int unsigned blanks;
		bit [5:0]    word_hits;
		bit          dollar_led;
		bit          overflowed;
		bit          after_exp;
		span_t       batch[$];

		function new();
			words      = '{"true", "false", "null", "undefined", "NaN", "Infinity"};
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			mode       = SCAN_IDLE;
			position   = 0;
			tok_start  = 0;
			tok_len    = 0;
			blanks     = 0;
			word_hits  = 6'h3F;
			dollar_led = 1'b0;
			overflowed = 1'b0;
			after_exp  = 1'b0;
		endfunction

		function int unsigned sat_inc(int unsigned v);
			return (v >= PosMax) ? PosMax : v + 1;
		endfunction

		function bit is_blank(bit [7:0] c);
			return c == " " || c == "\t";
		endfunction

		function bit is_digit(bit [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function bit id_start(bit [7:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c == "$";
		endfunction

		// Queue one span for this word, at most three per word
		function void add(int unsigned start, int unsigned len, span_class_t cls);
			span_t s;
			if (batch.size() >= MaxSpans)
				return;
			s.start  = start[15:0];
			s.length = len[15:0];
			s.cls    = cls;
			s.last   = 1'b0;
			s.ovf    = 1'b0;
			batch.insert(batch.size(), s);
		endfunction

		// Release the blanks held during a lookahead as one plain span
		function void add_blanks();
			int unsigned s;
			if (blanks == 0)
				return;
			s = tok_start + tok_len;
			if (s > PosMax)
				s = PosMax;
			add(s, blanks, CLS_PLAIN);
		endfunction

		// Drop every literal word that disagrees at this offset
		function void narrow_hits(int unsigned idx, bit [7:0] c);
			for (int w = 0; w < 6; w++) begin
				if (idx >= words[w].len() || words[w][idx] != c)
					word_hits[w] = 1'b0;
			end
		endfunction

		function span_class_t word_kind();
			for (int w = 0; w < 6; w++) begin
				if (word_hits[w] && tok_len == words[w].len())
					return CLS_LITERAL;
			end
			return dollar_led ? CLS_OPERATOR : CLS_IDENT;
		endfunction

		// Advance the scanner by one accepted text word
		function void take_byte(bit [7:0] c, bit eot);
			int unsigned p;
			bit          again;
			p     = position;
			again = 1'b0;
			batch.delete();
			if (position >= PosMax)
				overflowed = 1'b1;
			else
				position++;

			case (mode)
				SCAN_STR: begin
					tok_len = sat_inc(tok_len);
					if (c == "\\") begin
						mode = SCAN_STR_ESC;
					end else if (c == "\"") begin
						mode   = SCAN_STR_DONE;
						blanks = 0;
					end
				end
				SCAN_STR_ESC: begin
					tok_len = sat_inc(tok_len);
					mode    = SCAN_STR;
				end
				SCAN_STR_DONE: begin
					if (is_blank(c)) begin
						blanks = sat_inc(blanks);
					end else begin
						add(tok_start, tok_len, (c == ":") ? CLS_KEY : CLS_STRING);
						add_blanks();
						again = 1'b1;
					end
				end
				SCAN_WORD: begin
					if (id_start(c) || is_digit(c)) begin
						narrow_hits(tok_len, c);
						tok_len = sat_inc(tok_len);
					end else if (is_blank(c)) begin
						mode   = SCAN_WORD_DONE;
						blanks = 1;
					end else begin
						add(tok_start, tok_len, (c == "(") ? CLS_CALL : word_kind());
						again = 1'b1;
					end
				end
				SCAN_WORD_DONE: begin
					if (is_blank(c)) begin
						blanks = sat_inc(blanks);
					end else begin
						add(tok_start, tok_len, (c == "(") ? CLS_CALL : word_kind());
						add_blanks();
						again = 1'b1;
					end
				end
				SCAN_MINUS: begin
					if (is_digit(c)) begin
						mode      = SCAN_NUM;
						tok_len   = sat_inc(tok_len);
						after_exp = 1'b0;
					end else begin
						add(tok_start, 1, CLS_PLAIN);
						again = 1'b1;
					end
				end
				SCAN_NUM: begin
					if (is_digit(c) || c inside {".", "e", "E"}
							|| (c inside {"+", "-"} && after_exp)) begin
						tok_len   = sat_inc(tok_len);
						after_exp = c inside {"e", "E"};
					end else begin
						add(tok_start, tok_len, CLS_NUMBER);
						again = 1'b1;
					end
				end
				default: again = 1'b1;
			endcase

			// Start a new token from this word
			if (again) begin
				mode   = SCAN_IDLE;
				blanks = 0;
				if (is_blank(c)) begin
					add(p, 1, CLS_PLAIN);
				end else begin
					tok_start = p;
					tok_len   = 1;
					if (c == "\"") begin
						mode = SCAN_STR;
					end else if (id_start(c)) begin
						mode      = SCAN_WORD;
						word_hits = 6'h3F;
						narrow_hits(0, c);
						dollar_led = (c == "$");
					end else if (is_digit(c)) begin
						mode      = SCAN_NUM;
						after_exp = 1'b0;
					end else if (c == "-") begin
						mode = SCAN_MINUS;
					end else begin
						add(p, 1, (c inside {"{", "}", "[", "]", ",", ":"}) ?
							CLS_PUNCT : CLS_PLAIN);
					end
				end
			end

			// Flush whatever is still open at the end of the text
			if (eot) begin
				case (mode)
					SCAN_STR, SCAN_STR_ESC, SCAN_STR_DONE: begin
						add(tok_start, tok_len, CLS_STRING);
						add_blanks();
					end
					SCAN_WORD, SCAN_WORD_DONE: begin
						add(tok_start, tok_len, word_kind());
						add_blanks();
					end
					SCAN_MINUS: add(tok_start, 1, CLS_PLAIN);
					SCAN_NUM:   add(tok_start, tok_len, CLS_NUMBER);
					default: ;
				endcase
			end

			foreach (batch[i])
				batch[i].ovf = overflowed;
			if (eot) begin
				if (batch.size() > 0)
					batch[batch.size() - 1].last = 1'b1;
				restart();
			end
			foreach (batch[i])
				spans_due.insert(spans_due.size(), batch[i]);
		endfunction

		function void compare(string field, logic [15:0] want, logic [15:0] seen);
			if (seen !== want) begin
				mismatches++;
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, seen);
			end
		endfunction

		// Check one span leaving the block against the oldest prediction
		function void check_span(logic [15:0] start, logic [15:0] len, logic [3:0] cls,
				logic last, logic ovf);
			span_t due;
			if (spans_due.size() == 0) begin
				mismatches++;
				$display("%0t: span with none due, expected nothing,", $time,
					" got start %0d length %0d class %0d", start, len, cls);
				return;
			end
			due = spans_due.pop_front();
			compare("span_start", due.start, start);
			compare("span_length", due.length, len);
			compare("span_class", 16'(due.cls), 16'(cls));
			compare("final_span", 16'(due.last), 16'(last));
			compare("position_overflow", 16'(due.ovf), 16'(ovf));
		endfunction
	endclass

endpackage

@@ tb/sv/json_token_classifier_tb.sv @@
// ---------------------------------------------------------------------------
// json_token_classifier_tb: self-checking bench for the token classifier
// Feeds directed and randomly built JSON-like texts and a back-pressure burst,
// with the sender and receiver idling at random, and checks every span
// against a predicted span stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module json_token_classifier_tb;

	import jtc_pkg::*;
	import jtc_span_check_pkg::*;

	localparam int    StallLimit = 2000;
	localparam int    HoldCycles = 300;
	localparam string IdChars    = "truefalsNIinydxZ_";

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic [7:0]  text_byte   = 8'h00;
	logic        end_of_text = 1'b0;
	logic        out_ready   = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic [15:0] span_start;
	logic [15:0] span_length;
	logic [3:0]  span_class;
	logic        final_span;
	logic        position_overflow;

	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	bit          hold_armed     = 1'b0;
	bit          hold_done      = 1'b0;
	int          quiet_cycles   = 0;
	int unsigned bytes_sent     = 0;
	bit [7:0]    text_q[$];

	span_tracker tracker = new();

	json_token_classifier uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.text_byte         (text_byte),
		.end_of_text       (end_of_text),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.span_start        (span_start),
		.span_length       (span_length),
		.span_class        (span_class),
		.final_span        (final_span),
		.position_overflow (position_overflow)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Track accepted words on both channels and watch for a stuck block
	always @(posedge clk) begin
		if (in_valid && in_ready)
			tracker.take_byte(text_byte, end_of_text);
		if (out_valid && out_ready)
			tracker.check_span(span_start, span_length, span_class, final_span,
				position_overflow);
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= StallLimit) begin
			$display("%0t: no word accepted for %0d cycles", $time, StallLimit);
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Receiver: random stalls, plus one long hold-off when armed
	initial begin
		forever begin
			@(posedge clk);
			if (hold_armed && !hold_done) begin
				out_ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Append one byte to the text being built
	function automatic void put_byte(bit [7:0] b);
		text_q.insert(text_q.size(), b);
	endfunction

	function automatic void put_string(string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endfunction

	function automatic void add_letters(int n);
		repeat (n) put_byte(IdChars[$urandom_range(0, IdChars.len() - 1)]);
	endfunction

	function automatic void add_blanks(int n);
		repeat (n) put_byte($urandom_range(0, 1) ? " " : "\t");
	endfunction

	function automatic void add_digits(int n);
		repeat (n) put_byte(8'("0" + $urandom_range(0, 9)));
	endfunction

	// Append one mostly well-formed token with random content
	function automatic void add_token();
		string w;
		string puncts;
		puncts = "{}[],:";
		case ($urandom_range(0, 9))
			0: begin
				put_byte("\"");
				add_letters($urandom_range(1, 4));
				put_byte("\"");
				add_blanks($urandom_range(0, 2));
				put_byte(":");
			end
			1: begin
				put_byte("\"");
				repeat ($urandom_range(0, 5)) begin
					if ($urandom_range(0, 3) == 0) begin
						put_byte("\\");
						put_byte($urandom_range(0, 1) ? 8'("\"") : 8'($urandom_range(0, 255)));
					end else begin
						add_letters(1);
					end
				end
				if ($urandom_range(0, 9) != 0)
					put_byte("\"");
			end
			2: begin
				if ($urandom_range(0, 1))
					put_byte("-");
				add_digits($urandom_range(1, 3));
				if ($urandom_range(0, 1)) begin
					put_byte(".");
					add_digits($urandom_range(0, 2));
				end
				if ($urandom_range(0, 1)) begin
					put_byte($urandom_range(0, 1) ? "e" : "E");
					if ($urandom_range(0, 1))
						put_byte($urandom_range(0, 1) ? "+" : "-");
					add_digits($urandom_range(0, 2));
				end
			end
			3: begin
				w = tracker.words[$urandom_range(0, 5)];
				case ($urandom_range(0, 3))
					0: begin
						put_string(w);
						add_letters(1);
					end
					1: put_string(w.substr(0, w.len() - 2));
					default: put_string(w);
				endcase
			end
			4: begin
				put_byte("$");
				add_letters($urandom_range(0, 3));
			end
			5: begin
				add_letters($urandom_range(1, 4));
				add_blanks($urandom_range(0, 2));
				put_byte("(");
			end
			6: put_byte(puncts[$urandom_range(0, puncts.len() - 1)]);
			7: add_blanks($urandom_range(1, 3));
			8: put_byte(8'($urandom_range(0, 255)));
			default: begin
				if ($urandom_range(0, 1)) begin
					add_letters($urandom_range(1, 3));
					put_byte("_");
					add_digits(1);
				end else begin
					put_byte("-");
					add_letters(1);
				end
			end
		endcase
	endfunction

	// Offer the queued text word by word, end of text on the last
	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++) begin
			while ($urandom_range(0, 99) < send_idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid    <= 1'b1;
			text_byte   <= text_q[i];
			end_of_text <= (i == text_q.size() - 1);
			@(posedge clk);
			while (!in_ready) @(posedge clk);
		end
		bytes_sent += text_q.size();
		text_q.delete();
	endtask

	initial begin
		int unsigned mark;
		string       seps;
		seps = "  ,\t";

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed texts: keys, escapes, numbers, lone minus, literals, calls,
		// operator, lookahead at end, unterminated string, odd bytes
		put_string("{\"k\" :\"a\\\"b\",-1e-2,-}");
		send_text();
		put_string("f\t(NaN)$v -");
		send_text();
		put_string("null\t");
		send_text();
		put_string("\"s\" ");
		send_text();
		put_string("\"x");
		send_text();
		put_byte(8'hFF);
		send_text();
		put_byte(8'h00);
		send_text();

		// Random texts under each idling mix
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
				default: begin send_idle_pct = 6; recv_stall_pct = 6; end
			endcase
			mark = bytes_sent;
			while (bytes_sent - mark < 30) begin
				if ($urandom_range(0, 2) == 0)
					put_byte("{");
				repeat ($urandom_range(1, 8)) begin
					add_token();
					if ($urandom_range(0, 9) < 7)
						put_byte(seps[$urandom_range(0, seps.len() - 1)]);
				end
				send_text();
			end
		end

		// Hold the receiver off while blanks and commas keep coming, so the span
		// queue fills and the input stalls
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_armed    <= 1'b1;
		repeat (30) put_byte(seps[$urandom_range(0, seps.len() - 1)]);
		send_text();
		in_valid <= 1'b0;

		// Drain, then give the block time to show any stray span
		while (tracker.spans_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		if (tracker.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ json_token_classifier.f @@
src/jtc_pkg.sv
src/jtc_scanner.sv
src/jtc_span_queue.sv
src/json_token_classifier.sv
tb/sv/jtc_span_check_pkg.sv
tb/sv/json_token_classifier_tb.sv
